/* rtl/mi3_pkg.sv */
// Shared constants and the cofactor operand table for the 3x3 inverse block.
package mi3_pkg;

  localparam int unsigned DEF_DATA_WIDTH = 32;
  localparam int unsigned DEF_FRAC_BITS  = 16;
  localparam int unsigned NUM_ENT        = 9;

  typedef logic [3:0] idx_t;

  // cof[k] = m[i0]*m[i1] - m[i2]*m[i3]; m = {a0,a1,a2,b0,b1,b2,c0,c1,c2}
  localparam idx_t COF_IDX [0:NUM_ENT-1][0:3] = '{
    '{4'd4, 4'd8, 4'd5, 4'd7},
    '{4'd5, 4'd6, 4'd3, 4'd8},
    '{4'd3, 4'd7, 4'd4, 4'd6},
    '{4'd2, 4'd7, 4'd1, 4'd8},
    '{4'd0, 4'd8, 4'd2, 4'd6},
    '{4'd1, 4'd6, 4'd0, 4'd7},
    '{4'd1, 4'd5, 4'd2, 4'd4},
    '{4'd2, 4'd3, 4'd0, 4'd5},
    '{4'd0, 4'd4, 4'd1, 4'd3}
  };

endpackage

/* rtl/mi3_if.sv */
// Matrix input and inverse result channel interfaces.
interface mi3_in_if #(
  parameter int unsigned DATA_WIDTH = mi3_pkg::DEF_DATA_WIDTH
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] col0_x, col0_y, col0_z;
  logic signed [DATA_WIDTH-1:0] col1_x, col1_y, col1_z;
  logic signed [DATA_WIDTH-1:0] col2_x, col2_y, col2_z;

  modport source (output valid, col0_x, col0_y, col0_z, col1_x, col1_y, col1_z,
                  col2_x, col2_y, col2_z, input ready);
  modport sink   (input valid, col0_x, col0_y, col0_z, col1_x, col1_y, col1_z,
                  col2_x, col2_y, col2_z, output ready);
endinterface

interface mi3_out_if #(
  parameter int unsigned DATA_WIDTH = mi3_pkg::DEF_DATA_WIDTH
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] inv_r0c0, inv_r0c1, inv_r0c2;
  logic signed [DATA_WIDTH-1:0] inv_r1c0, inv_r1c1, inv_r1c2;
  logic signed [DATA_WIDTH-1:0] inv_r2c0, inv_r2c1, inv_r2c2;
  logic signed [DATA_WIDTH-1:0] determinant;
  logic                         singular;

  modport source (output valid, inv_r0c0, inv_r0c1, inv_r0c2, inv_r1c0, inv_r1c1,
                  inv_r1c2, inv_r2c0, inv_r2c1, inv_r2c2, determinant, singular,
                  input ready);
  modport sink   (input valid, inv_r0c0, inv_r0c1, inv_r0c2, inv_r1c0, inv_r1c1,
                  inv_r1c2, inv_r2c0, inv_r2c1, inv_r2c2, determinant, singular,
                  output ready);
endinterface

/* rtl/mi3_cof.sv */
// Cofactor pipeline: 18 products, then nine exact cofactors.
module mi3_cof #(
  parameter int unsigned W = mi3_pkg::DEF_DATA_WIDTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [W-1:0] mat [0:mi3_pkg::NUM_ENT-1],
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [W-1:0] a_out [0:2],
  output logic signed [2*W:0] cof_out [0:mi3_pkg::NUM_ENT-1]
);
  import mi3_pkg::*;

  localparam int unsigned PW = 2 * W;
  localparam int unsigned CW = 2 * W + 1;

  logic [1:0]           v_r;
  logic [2:0]           rdy;
  logic signed [PW-1:0] p_r   [0:2*NUM_ENT-1];
  logic signed [W-1:0]  a0_r  [0:2];
  logic signed [W-1:0]  a1_r  [0:2];
  logic signed [CW-1:0] cof_r [0:NUM_ENT-1];

  assign rdy[2]    = out_ready;
  assign rdy[1]    = !v_r[1] || rdy[2];
  assign rdy[0]    = !v_r[0] || rdy[1];
  assign in_ready  = rdy[0];
  assign out_valid = v_r[1];
  assign a_out     = a1_r;
  assign cof_out   = cof_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) v_r[0] <= in_valid;
      if (rdy[1]) v_r[1] <= v_r[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      for (int k = 0; k < NUM_ENT; k++) begin
        p_r[2*k]   <= PW'(mat[COF_IDX[k][0]]) * PW'(mat[COF_IDX[k][1]]);
        p_r[2*k+1] <= PW'(mat[COF_IDX[k][2]]) * PW'(mat[COF_IDX[k][3]]);
      end
      for (int k = 0; k < 3; k++) a0_r[k] <= mat[k];
    end
    if (rdy[1]) begin
      for (int k = 0; k < NUM_ENT; k++) cof_r[k] <= CW'(p_r[2*k]) - CW'(p_r[2*k+1]);
      a1_r <= a0_r;
    end
  end

endmodule

/* rtl/mi3_det.sv */
// Determinant pipeline: split products, recombine, three-term sum.
module mi3_det #(
  parameter int unsigned W = mi3_pkg::DEF_DATA_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic signed [W-1:0]   a_in [0:2],
  input  logic signed [2*W:0]   cof_in [0:mi3_pkg::NUM_ENT-1],
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [2*W:0]   cof_out [0:mi3_pkg::NUM_ENT-1],
  output logic signed [3*W+2:0] det_out
);
  import mi3_pkg::*;

  localparam int unsigned PW = 2 * W + 1;
  localparam int unsigned TW = 3 * W + 1;
  localparam int unsigned DW = 3 * W + 3;

  logic [2:0]           v_r;
  logic [3:0]           rdy;
  logic signed [PW-1:0] pl_r [0:2];
  logic signed [PW-1:0] ph_r [0:2];
  logic signed [TW-1:0] t_r  [0:2];
  logic signed [DW-1:0] det_r;
  logic signed [PW-1:0] cof0_r [0:NUM_ENT-1];
  logic signed [PW-1:0] cof1_r [0:NUM_ENT-1];
  logic signed [PW-1:0] cof2_r [0:NUM_ENT-1];

  assign rdy[3]    = out_ready;
  assign rdy[2]    = !v_r[2] || rdy[3];
  assign rdy[1]    = !v_r[1] || rdy[2];
  assign rdy[0]    = !v_r[0] || rdy[1];
  assign in_ready  = rdy[0];
  assign out_valid = v_r[2];
  assign cof_out   = cof2_r;
  assign det_out   = det_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) v_r[0] <= in_valid;
      if (rdy[1]) v_r[1] <= v_r[0];
      if (rdy[2]) v_r[2] <= v_r[1];
    end
  end

  // a * cof split at bit W: low part unsigned, high part signed
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      for (int k = 0; k < 3; k++) begin
        pl_r[k] <= PW'(a_in[k]) * PW'($signed({1'b0, cof_in[k][W-1:0]}));
        ph_r[k] <= PW'(a_in[k]) * PW'($signed(cof_in[k][2*W:W]));
      end
      cof0_r <= cof_in;
    end
    if (rdy[1]) begin
      for (int k = 0; k < 3; k++) t_r[k] <= (TW'(ph_r[k]) << W) + TW'(pl_r[k]);
      cof1_r <= cof0_r;
    end
    if (rdy[2]) begin
      det_r  <= DW'(t_r[0]) + DW'(t_r[1]) + DW'(t_r[2]);
      cof2_r <= cof1_r;
    end
  end

endmodule

/* rtl/mi3_div.sv */
// Nine-lane pipelined restoring divider with saturation and singular handling.
module mi3_div #(
  parameter int unsigned W = mi3_pkg::DEF_DATA_WIDTH,
  parameter int unsigned F = mi3_pkg::DEF_FRAC_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic signed [2*W:0]   cof_in [0:mi3_pkg::NUM_ENT-1],
  input  logic signed [3*W+2:0] det_in,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [W-1:0]   inv_out [0:mi3_pkg::NUM_ENT-1],
  output logic signed [W-1:0]   det_out,
  output logic                  sing_out
);
  import mi3_pkg::*;

  localparam int unsigned CW = 2 * W + 1;
  localparam int unsigned DW = 3 * W + 3;
  localparam int unsigned NW = CW + 2 * F;
  localparam int unsigned RW = ((NW > DW) ? NW : DW) + 1;
  localparam int unsigned NS = W + 3;

  typedef struct packed {
    logic [RW-1:0] rem;
    logic [W-1:0]  nlo;
    logic [W-1:0]  q;
    logic          neg;
    logic          ovf;
  } lane_t;

  typedef struct packed {
    logic [DW-1:0] dm;
    logic          dn;
    logic          dz;
  } dinf_t;

  localparam logic [W-1:0] SAT_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] SAT_MIN = {1'b1, {(W-1){1'b0}}};

  logic [NS-1:0]        v_r;
  logic [NS:0]          rdy;
  logic [CW-1:0]        cm0_r [0:NUM_ENT-1];
  logic [NUM_ENT-1:0]   cn0_r;
  dinf_t                dinf_r [0:W+1];
  lane_t                ln_r [1:W+1][0:NUM_ENT-1];
  logic signed [W-1:0]  inv_r [0:NUM_ENT-1];
  logic signed [W-1:0]  det_o_r;
  logic                 sing_r;

  assign rdy[NS] = out_ready;
  for (genvar s = 0; s < NS; s++) begin : g_rdy
    assign rdy[s] = !v_r[s] || rdy[s+1];
  end
  assign in_ready  = rdy[0];
  assign out_valid = v_r[NS-1];
  assign inv_out   = inv_r;
  assign det_out   = det_o_r;
  assign sing_out  = sing_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) v_r[0] <= in_valid;
      for (int s = 1; s < NS; s++) begin
        if (rdy[s]) v_r[s] <= v_r[s-1];
      end
    end
  end

  // magnitudes and signs
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      for (int l = 0; l < NUM_ENT; l++) begin
        cm0_r[l] <= CW'(cof_in[l][CW-1] ? -cof_in[l] : cof_in[l]);
        cn0_r[l] <= cof_in[l][CW-1];
      end
      dinf_r[0].dm <= DW'(det_in[DW-1] ? -det_in : det_in);
      dinf_r[0].dn <= det_in[DW-1];
      dinf_r[0].dz <= (det_in == '0);
    end
  end

  for (genvar s = 1; s <= W + 1; s++) begin : g_dinf
    always_ff @(posedge clk) begin
      if (rdy[s]) dinf_r[s] <= dinf_r[s-1];
    end
  end

  // quotient fits in W bits only if (num >> W) < det
  for (genvar l = 0; l < NUM_ENT; l++) begin : g_init
    logic [NW-1:0] num;
    logic [RW-1:0] hi;
    lane_t         ln_nxt;
    always_comb begin
      num        = {cm0_r[l], {(2*F){1'b0}}};
      hi         = RW'(num[NW-1:W]);
      ln_nxt.ovf = (hi >= RW'(dinf_r[0].dm));
      ln_nxt.rem = ln_nxt.ovf ? '0 : hi;
      ln_nxt.nlo = num[W-1:0];
      ln_nxt.q   = '0;
      ln_nxt.neg = cn0_r[l] ^ dinf_r[0].dn;
    end
    always_ff @(posedge clk) begin
      if (rdy[1]) ln_r[1][l] <= ln_nxt;
    end
  end

  // one quotient bit per stage
  for (genvar s = 2; s <= W + 1; s++) begin : g_it
    for (genvar l = 0; l < NUM_ENT; l++) begin : g_ln
      lane_t         cur;
      lane_t         ln_nxt;
      logic [RW-1:0] r2;
      logic          ge;
      always_comb begin
        cur        = ln_r[s-1][l];
        r2         = {cur.rem[RW-2:0], cur.nlo[W-1]};
        ge         = (r2 >= RW'(dinf_r[s-1].dm));
        ln_nxt     = cur;
        ln_nxt.rem = ge ? (r2 - RW'(dinf_r[s-1].dm)) : r2;
        ln_nxt.nlo = {cur.nlo[W-2:0], 1'b0};
        ln_nxt.q   = {cur.q[W-2:0], ge};
      end
      always_ff @(posedge clk) begin
        if (rdy[s]) ln_r[s][l] <= ln_nxt;
      end
    end
  end

  // saturation, sign and singular override
  for (genvar l = 0; l < NUM_ENT; l++) begin : g_fin
    lane_t        fl;
    logic [W-1:0] inv_nxt;
    always_comb begin
      fl = ln_r[W+1][l];
      if (dinf_r[W+1].dz) begin
        inv_nxt = '0;
      end else if (fl.neg) begin
        if (fl.ovf || (fl.q[W-1] && (|fl.q[W-2:0]))) inv_nxt = SAT_MIN;
        else inv_nxt = -fl.q;
      end else begin
        if (fl.ovf || fl.q[W-1]) inv_nxt = SAT_MAX;
        else inv_nxt = fl.q;
      end
    end
    always_ff @(posedge clk) begin
      if (rdy[NS-1]) inv_r[l] <= $signed(inv_nxt);
    end
  end

  logic [DW-1:0] dsh;
  logic [W-1:0]  det_nxt;
  always_comb begin
    dsh = dinf_r[W+1].dm >> (2 * F);
    if (dinf_r[W+1].dn) begin
      if ((|dsh[DW-1:W]) || (dsh[W-1] && (|dsh[W-2:0]))) det_nxt = SAT_MIN;
      else det_nxt = -dsh[W-1:0];
    end else begin
      if (|dsh[DW-1:W-1]) det_nxt = SAT_MAX;
      else det_nxt = dsh[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[NS-1]) begin
      det_o_r <= $signed(det_nxt);
      sing_r  <= dinf_r[W+1].dz;
    end
  end

endmodule

/* rtl/matrix3_inverse_determinant.sv */
// Top level of the 3x3 matrix inverse and determinant block.
//
// in_ch takes one matrix per item as three signed fixed-point column vectors.
// out_ch gives the nine inverse entries (row-major), the determinant and a
// singular flag, one result item per input item, in order.
// Inverse entries are cofactor * 2^(2*FRAC_BITS) / det, truncated toward zero
// and saturated; determinant is det >> 2*FRAC_BITS, truncated and saturated.
// A zero determinant gives singular = 1 and all-zero entries.
// The pipeline has two cofactor stages, three determinant stages, and a
// divider with one stage per quotient bit plus setup and output stages.
// Throughput: one item per cycle while out_ch.ready stays high, set by the
// fully pipelined divider lanes.
// When the receiver stalls, items collapse into empty stages; in_ch.ready
// drops only once every stage holds an item. Nothing is lost or repeated.
// Reset (synchronous, rst_n low) empties the pipeline; no item is in flight.
module matrix3_inverse_determinant #(
  parameter int unsigned DATA_WIDTH = mi3_pkg::DEF_DATA_WIDTH,
  parameter int unsigned FRAC_BITS  = mi3_pkg::DEF_FRAC_BITS
) (
  input logic  clk,
  input logic  rst_n,
  mi3_in_if.sink    in_ch,
  mi3_out_if.source out_ch
);
  import mi3_pkg::*;

  localparam int unsigned W = DATA_WIDTH;

  logic signed [W-1:0]   mat     [0:NUM_ENT-1];
  logic signed [W-1:0]   a_c     [0:2];
  logic signed [2*W:0]   cof_c   [0:NUM_ENT-1];
  logic signed [2*W:0]   cof_d   [0:NUM_ENT-1];
  logic signed [3*W+2:0] det_d;
  logic signed [W-1:0]   inv     [0:NUM_ENT-1];
  logic                  c_valid, c_ready, d_valid, d_ready;

  assign mat[0] = in_ch.col0_x;
  assign mat[1] = in_ch.col0_y;
  assign mat[2] = in_ch.col0_z;
  assign mat[3] = in_ch.col1_x;
  assign mat[4] = in_ch.col1_y;
  assign mat[5] = in_ch.col1_z;
  assign mat[6] = in_ch.col2_x;
  assign mat[7] = in_ch.col2_y;
  assign mat[8] = in_ch.col2_z;

  mi3_cof #(.W(W)) u_cof (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .mat       (mat),
    .out_valid (c_valid),
    .out_ready (c_ready),
    .a_out     (a_c),
    .cof_out   (cof_c)
  );

  mi3_det #(.W(W)) u_det (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (c_valid),
    .in_ready  (c_ready),
    .a_in      (a_c),
    .cof_in    (cof_c),
    .out_valid (d_valid),
    .out_ready (d_ready),
    .cof_out   (cof_d),
    .det_out   (det_d)
  );

  mi3_div #(.W(W), .F(FRAC_BITS)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (d_valid),
    .in_ready  (d_ready),
    .cof_in    (cof_d),
    .det_in    (det_d),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .inv_out   (inv),
    .det_out   (out_ch.determinant),
    .sing_out  (out_ch.singular)
  );

  assign out_ch.inv_r0c0 = inv[0];
  assign out_ch.inv_r0c1 = inv[1];
  assign out_ch.inv_r0c2 = inv[2];
  assign out_ch.inv_r1c0 = inv[3];
  assign out_ch.inv_r1c1 = inv[4];
  assign out_ch.inv_r1c2 = inv[5];
  assign out_ch.inv_r2c0 = inv[6];
  assign out_ch.inv_r2c1 = inv[7];
  assign out_ch.inv_r2c2 = inv[8];

endmodule

/* rtl/mi3_chk.sv */
// Port-level checker for the 3x3 inverse block, with its bind.
module mi3_chk #(
  parameter int unsigned W = mi3_pkg::DEF_DATA_WIDTH
) (
  input logic         clk,
  input logic         rst_n,
  input logic         in_ready,
  input logic         out_valid,
  input logic         out_ready,
  input logic         inv_nz,
  input logic [W-1:0] det,
  input logic         singular
);

  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result item valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(det) && $stable(singular))
    else $error("stalled result item changed");

  a_sing: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && singular |-> !inv_nz && (det == '0))
    else $error("singular item with nonzero entries");

  a_bp: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output back-pressure");

endmodule

bind matrix3_inverse_determinant mi3_chk #(.W(DATA_WIDTH)) u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .inv_nz    (|{out_ch.inv_r0c0, out_ch.inv_r0c1, out_ch.inv_r0c2,
                out_ch.inv_r1c0, out_ch.inv_r1c1, out_ch.inv_r1c2,
                out_ch.inv_r2c0, out_ch.inv_r2c1, out_ch.inv_r2c2}),
  .det       (out_ch.determinant),
  .singular  (out_ch.singular)
);

/* bench/matrix3_inverse_determinant_tb.sv */
// Testbench for the 3x3 fixed-point matrix inverse and determinant block.
`timescale 1ns / 100ps

module matrix3_inverse_determinant_tb;
  import mi3_pkg::*;

  localparam int DW = DEF_DATA_WIDTH;
  localparam int FB = DEF_FRAC_BITS;
  localparam int LATENCY = DW + 8;
  localparam int WATCHDOG = 4000;

  typedef logic signed [DW-1:0] fx_t;
  typedef logic signed [191:0] big_t;

  typedef struct {
    fx_t m [9];
  } matrix_t;

  typedef struct {
    fx_t inv [9];
    fx_t det;
    logic sing;
  } inverse_t;

  logic clk;
  logic rst_n;
  mi3_in_if  #(.DATA_WIDTH(DW)) in_ch ();
  mi3_out_if #(.DATA_WIDTH(DW)) out_ch ();

  matrix3_inverse_determinant #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch)
  );

  matrix_t pending_q [$];
  inverse_t expected_q [$];
  int failures = 0;
  int idle_cycles = 0;
  bit stim_done = 0;
  bit hold_active = 0;
  int hold_left = 0;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  function automatic fx_t clamp(big_t v);
    big_t hi;
    big_t lo;
    hi = (big_t'(1) <<< (DW - 1)) - 1;
    lo = -(big_t'(1) <<< (DW - 1));
    if (v > hi) return fx_t'(hi);
    if (v < lo) return fx_t'(lo);
    return fx_t'(v);
  endfunction

  // Adjugate inverse: exact cofactors and determinant, quotient truncated toward zero.
  function automatic inverse_t invert(matrix_t x);
    inverse_t r;
    big_t e [9];
    big_t cof [9];
    big_t det;
    big_t q;
    for (int i = 0; i < 9; i++) e[i] = big_t'(x.m[i]);
    // e: a0 a1 a2 b0 b1 b2 c0 c1 c2
    cof[0] = e[4] * e[8] - e[5] * e[7];
    cof[1] = e[5] * e[6] - e[3] * e[8];
    cof[2] = e[3] * e[7] - e[4] * e[6];
    cof[3] = e[2] * e[7] - e[1] * e[8];
    cof[4] = e[0] * e[8] - e[2] * e[6];
    cof[5] = e[1] * e[6] - e[0] * e[7];
    cof[6] = e[1] * e[5] - e[2] * e[4];
    cof[7] = e[2] * e[3] - e[0] * e[5];
    cof[8] = e[0] * e[4] - e[1] * e[3];
    det = e[0] * cof[0] + e[1] * cof[1] + e[2] * cof[2];
    r.sing = (det == 0);
    for (int i = 0; i < 9; i++) begin
      if (r.sing) begin
        r.inv[i] = '0;
      end else begin
        q = (cof[i] <<< (2 * FB)) / det;
        r.inv[i] = clamp(q);
      end
    end
    if (det < 0) q = -((-det) >>> (2 * FB));
    else q = det >>> (2 * FB);
    r.det = clamp(q);
    return r;
  endfunction

  function automatic fx_t rand_fx(int mode);
    fx_t v;
    case (mode)
      0: v = fx_t'($urandom);
      1: v = fx_t'($urandom_range(0, 'h3FFFF)) - fx_t'('h20000);
      2: v = fx_t'($urandom_range(0, 'h7FFFFF)) - fx_t'('h400000);
      default: v = fx_t'($urandom_range(0, 6)) - 3;
    endcase
    return v;
  endfunction

  task automatic push_matrix(fx_t a0, fx_t a1, fx_t a2, fx_t b0, fx_t b1, fx_t b2,
                             fx_t c0, fx_t c1, fx_t c2);
    matrix_t x;
    x.m = '{a0, a1, a2, b0, b1, b2, c0, c1, c2};
    pending_q.push_back(x);
  endtask

  initial begin
    fx_t one, mx, mn;
    matrix_t x;
    int mode;
    one = fx_t'(1 << FB);
    mx = {1'b0, {(DW-1){1'b1}}};
    mn = {1'b1, {(DW-1){1'b0}}};
    push_matrix(one, 0, 0, 0, one, 0, 0, 0, one);
    push_matrix(-one, 0, 0, 0, one, 0, 0, 0, one);
    push_matrix(2 * one, 0, 0, 0, 4 * one, 0, 0, 0, one / 2);
    push_matrix(0, 0, 0, 0, 0, 0, 0, 0, 0);
    push_matrix(one, one, one, one, one, one, one, one, one);
    push_matrix(one, 2 * one, 0, 2 * one, 4 * one, 0, 0, 0, one);
    push_matrix(1, 0, 0, 0, 1, 0, 0, 0, 1);
    push_matrix(one, 0, 0, 0, one, 0, 0, 0, 1);
    push_matrix(mx, 0, 0, 0, mx, 0, 0, 0, mx);
    push_matrix(mn, 0, 0, 0, mn, 0, 0, 0, mn);
    push_matrix(mx, mn, mx, mn, mx, mn, mx, mn, mn);
    push_matrix(-1, -1, 0, 1, -1, 0, 0, 0, -1);
    push_matrix(0, one, 0, one, 0, 0, 0, 0, one);
    push_matrix(mn, mx, 0, 0, mn, mx, mx, 0, mn);
    push_matrix(-1, 0, 0, 0, -1, 0, 0, 0, -1);
    push_matrix(one, 3, 5, 7, one, 11, 13, 17, one);
    for (int n = 0; n < 800; n++) begin
      mode = $urandom_range(0, 3);
      for (int i = 0; i < 9; i++) x.m[i] = rand_fx(mode);
      if ($urandom_range(0, 9) == 0) begin
        // dependent rows or columns give a singular matrix
        for (int i = 0; i < 3; i++) x.m[6 + i] = x.m[i];
      end
      pending_q.push_back(x);
    end
  end

  // Driver
  int gap = 0;
  int sent = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      {in_ch.col0_x, in_ch.col0_y, in_ch.col0_z} <= '0;
      {in_ch.col1_x, in_ch.col1_y, in_ch.col1_z} <= '0;
      {in_ch.col2_x, in_ch.col2_y, in_ch.col2_z} <= '0;
      gap <= $urandom_range(0, 14);
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        sent <= sent + 1;
        if ((sent / 100) % 2 == 1) gap <= 0;
        else gap <= $urandom_range(0, 14);
      end
      if (in_ch.valid && !in_ch.ready) begin
      end else if ((in_ch.valid && in_ch.ready ? 0 : gap) == 0 && pending_q.size() > 0 &&
                   !(in_ch.valid && in_ch.ready && (sent / 100) % 2 == 0 &&
                     $urandom_range(0, 1) == 1)) begin
        in_ch.valid <= 1'b1;
        {in_ch.col0_x, in_ch.col0_y, in_ch.col0_z} <= {pending_q[0].m[0], pending_q[0].m[1],
                                                        pending_q[0].m[2]};
        {in_ch.col1_x, in_ch.col1_y, in_ch.col1_z} <= {pending_q[0].m[3], pending_q[0].m[4],
                                                        pending_q[0].m[5]};
        {in_ch.col2_x, in_ch.col2_y, in_ch.col2_z} <= {pending_q[0].m[6], pending_q[0].m[7],
                                                        pending_q[0].m[8]};
        expected_q.push_back(invert(pending_q[0]));
        pending_q.pop_front();
      end else begin
        in_ch.valid <= 1'b0;
        if (gap > 0 && !(in_ch.valid && in_ch.ready)) gap <= gap - 1;
      end
      if (pending_q.size() == 0 && !in_ch.valid) stim_done <= 1;
    end
  end

  // Monitor
  int stall = 0;
  int got = 0;
  always @(posedge clk) begin
    inverse_t e;
    fx_t act [9];
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall <= $urandom_range(0, 14);
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got <= got + 1;
        act = '{out_ch.inv_r0c0, out_ch.inv_r0c1, out_ch.inv_r0c2,
                out_ch.inv_r1c0, out_ch.inv_r1c1, out_ch.inv_r1c2,
                out_ch.inv_r2c0, out_ch.inv_r2c1, out_ch.inv_r2c2};
        if (expected_q.size() == 0) begin
          $error("result item with nothing expected");
          failures++;
        end else begin
          e = expected_q.pop_front();
          for (int i = 0; i < 9; i++)
            if (act[i] !== e.inv[i]) begin
              $error("inv_r%0dc%0d expected %0d got %0d", i / 3, i % 3, e.inv[i], act[i]);
              failures++;
            end
          if (out_ch.determinant !== e.det) begin
            $error("determinant expected %0d got %0d", e.det, out_ch.determinant);
            failures++;
          end
          if (out_ch.singular !== e.sing) begin
            $error("singular expected %0d got %0d", e.sing, out_ch.singular);
            failures++;
          end
        end
      end
      if (got == 300 && !hold_active && hold_left == 0) begin
        hold_active <= 1;
        hold_left <= 200;
        out_ch.ready <= 1'b0;
      end else if (hold_active) begin
        if (hold_left == 1) hold_active <= 0;
        hold_left <= hold_left - 1;
        out_ch.ready <= (hold_left == 1);
      end else if (out_ch.valid && out_ch.ready) begin
        stall <= ((got / 100) % 2 == 1) ? 0 : $urandom_range(0, 14);
        out_ch.ready <= ((got / 100) % 2 == 1);
      end else if (stall > 0) begin
        stall <= stall - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    rst_n = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1;
    while (!(stim_done && expected_q.size() == 0)) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
    if (failures == 0 && expected_q.size() == 0 && !out_ch.valid) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
